### rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// shared types and constants of the two-level page table manager
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int IDX_W         = 10;
	localparam int OFS_W         = 12;
	localparam int FRAME_W       = 20;
	localparam int ADDR_W        = 32;
	localparam int FLAGS_W       = 12;
	localparam int CMD_W         = 2;
	localparam int STATUS_W      = 2;
	localparam int DIR_ENTRIES   = 1024;
	localparam int TABLE_ENTRIES = 1024;
	localparam int FLAG_PRESENT  = 0;
	localparam int FLAG_USER     = 2;

	localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_XLATE = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NO_TABLE   = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOT_MAPPED = 2'd2;

	typedef enum logic [1:0] {
		OP_MAP,
		OP_UNMAP,
		OP_XLATE,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_ISSUE,
		BK_DIR,
		BK_TBL
	} bk_state_t;

	// one classified command waiting for the back end
	typedef struct packed {
		op_t                op;
		logic [IDX_W-1:0]   dir_idx;
		logic [IDX_W-1:0]   tbl_idx;
		logic [OFS_W-1:0]   offset;
		logic [FRAME_W-1:0] frame;
		logic [FLAGS_W-1:0] flags;
	} item_t;

endpackage

### rtl/tlpt_req_if.sv
// ----------------------------------------------------------------------------
// tlpt_req_if
// command channel: valid/ready with map, unmap and translate requests
// ----------------------------------------------------------------------------
interface tlpt_req_if;
	logic                              valid;
	logic                              ready;
	logic [tlpt_pkg::CMD_W-1:0]        cmd;
	logic [tlpt_pkg::ADDR_W-1:0]       virt_addr;
	logic [tlpt_pkg::ADDR_W-1:0]       phys_addr;
	logic [tlpt_pkg::FLAGS_W-1:0]      page_flags;

	modport source (output valid, cmd, virt_addr, phys_addr, page_flags, input ready);
	modport sink (input valid, cmd, virt_addr, phys_addr, page_flags, output ready);
endinterface

### rtl/tlpt_rsp_if.sv
// ----------------------------------------------------------------------------
// tlpt_rsp_if
// result channel: valid/ready with status and translated address
// ----------------------------------------------------------------------------
interface tlpt_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [tlpt_pkg::STATUS_W-1:0]     status;
	logic [tlpt_pkg::ADDR_W-1:0]       phys_result;

	modport source (output valid, status, phys_result, input ready);
	modport sink (input valid, status, phys_result, output ready);
endinterface

### rtl/tlpt_front.sv
// ----------------------------------------------------------------------------
// tlpt_front
// accepts commands, splits the address fields and queues them (two entries)
// ----------------------------------------------------------------------------
module tlpt_front (
	input  logic              clk,
	input  logic              arst_n,
	tlpt_req_if.sink          req,
	output logic              q_valid,
	output tlpt_pkg::item_t   q_item,
	input  logic              q_pop
);

	tlpt_pkg::item_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	tlpt_pkg::item_t item_in;
	logic            push;

	always_comb begin
		item_in.dir_idx = req.virt_addr[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::IDX_W];
		item_in.tbl_idx = req.virt_addr[tlpt_pkg::OFS_W +: tlpt_pkg::IDX_W];
		item_in.offset  = req.virt_addr[tlpt_pkg::OFS_W-1:0];
		item_in.frame   = req.phys_addr[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::FRAME_W];
		item_in.flags   = req.page_flags;
		case (req.cmd)
			tlpt_pkg::CMD_MAP:   item_in.op = tlpt_pkg::OP_MAP;
			tlpt_pkg::CMD_UNMAP: item_in.op = tlpt_pkg::OP_UNMAP;
			tlpt_pkg::CMD_XLATE: item_in.op = tlpt_pkg::OP_XLATE;
			default:             item_in.op = tlpt_pkg::OP_NOP;
		endcase
	end

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (count_q != 2'd0);
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/tlpt_back.sv
// ----------------------------------------------------------------------------
// tlpt_back
// directory and table memories, command sequencer and result register
// ----------------------------------------------------------------------------
module tlpt_back #(
	parameter int TABLE_POOL = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  tlpt_pkg::item_t   q_item,
	output logic              q_pop,
	tlpt_rsp_if.source        rsp
);

	localparam int SLOT_W  = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
	localparam int USED_W  = $clog2(TABLE_POOL + 1);
	localparam int TDEPTH  = TABLE_POOL * tlpt_pkg::TABLE_ENTRIES;
	localparam int TADDR_W = SLOT_W + tlpt_pkg::IDX_W;
	// directory entry: slot, user, present (write bit is implied by present)
	localparam int DIR_W   = SLOT_W + 2;

	logic [DIR_W-1:0]            dir_mem [tlpt_pkg::DIR_ENTRIES];
	logic [tlpt_pkg::ADDR_W-1:0] tbl_mem [TDEPTH];

	tlpt_pkg::bk_state_t         state_q, state_d;
	tlpt_pkg::item_t             cur_q;
	logic [DIR_W-1:0]            dir_rd_q;
	logic [tlpt_pkg::ADDR_W-1:0] tbl_rd_q;
	logic [USED_W-1:0]           used_q;
	logic [TADDR_W-1:0]          clr_q;

	logic                        dir_we;
	logic [tlpt_pkg::IDX_W-1:0]  dir_wa;
	logic [DIR_W-1:0]            dir_wd;
	logic                        tbl_we;
	logic [TADDR_W-1:0]          tbl_wa;
	logic [tlpt_pkg::ADDR_W-1:0] tbl_wd;
	logic                        tbl_re;
	logic [TADDR_W-1:0]          tbl_ra;
	logic                        used_inc;
	logic                        clr_run;

	logic                        res_valid_q;
	logic [tlpt_pkg::STATUS_W-1:0] res_status_q;
	logic [tlpt_pkg::ADDR_W-1:0] res_phys_q;
	logic                        res_load;
	logic [tlpt_pkg::STATUS_W-1:0] res_status_d;
	logic [tlpt_pkg::ADDR_W-1:0] res_phys_d;
	logic                        out_free;

	assign out_free = !res_valid_q || rsp.ready;

	always_comb begin
		logic                present;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   new_slot;
		logic [tlpt_pkg::ADDR_W-1:0] map_entry;

		present   = dir_rd_q[0];
		slot      = dir_rd_q[DIR_W-1:2];
		new_slot  = used_q[SLOT_W-1:0];
		map_entry = {cur_q.frame, cur_q.flags[tlpt_pkg::FLAGS_W-1:1], 1'b1};

		state_d      = state_q;
		q_pop        = 1'b0;
		dir_we       = 1'b0;
		dir_wa       = cur_q.dir_idx;
		dir_wd       = '0;
		tbl_we       = 1'b0;
		tbl_wa       = {slot, cur_q.tbl_idx};
		tbl_wd       = '0;
		tbl_re       = 1'b0;
		tbl_ra       = {slot, cur_q.tbl_idx};
		used_inc     = 1'b0;
		clr_run      = 1'b0;
		res_load     = 1'b0;
		res_status_d = tlpt_pkg::STS_OK;
		res_phys_d   = '0;

		case (state_q)
			tlpt_pkg::BK_CLEAR: begin
				// sweep both stores once after reset
				clr_run = 1'b1;
				dir_we  = 1'b1;
				dir_wa  = clr_q[tlpt_pkg::IDX_W-1:0];
				tbl_we  = 1'b1;
				tbl_wa  = clr_q;
				if (clr_q == TADDR_W'(TDEPTH - 1)) begin
					state_d = tlpt_pkg::BK_ISSUE;
				end
			end
			tlpt_pkg::BK_ISSUE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = tlpt_pkg::BK_DIR;
				end
			end
			tlpt_pkg::BK_DIR: begin
				if (out_free) begin
					state_d  = tlpt_pkg::BK_ISSUE;
					res_load = 1'b1;
					case (cur_q.op)
						tlpt_pkg::OP_MAP: begin
							if (!present) begin
								if (used_q == USED_W'(TABLE_POOL)) begin
									res_status_d = tlpt_pkg::STS_NO_TABLE;
								end else begin
									// fresh slot is still zero since reset
									used_inc = 1'b1;
									dir_we   = 1'b1;
									dir_wd   = {new_slot, cur_q.flags[tlpt_pkg::FLAG_USER], 1'b1};
									tbl_we   = 1'b1;
									tbl_wa   = {new_slot, cur_q.tbl_idx};
									tbl_wd   = map_entry;
								end
							end else begin
								tbl_we = 1'b1;
								tbl_wd = map_entry;
							end
						end
						tlpt_pkg::OP_UNMAP: begin
							tbl_we = present;
						end
						tlpt_pkg::OP_XLATE: begin
							if (present) begin
								tbl_re   = 1'b1;
								res_load = 1'b0;
								state_d  = tlpt_pkg::BK_TBL;
							end else begin
								res_status_d = tlpt_pkg::STS_NOT_MAPPED;
								res_phys_d   = '1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			tlpt_pkg::BK_TBL: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = tlpt_pkg::BK_ISSUE;
					if (tbl_rd_q[tlpt_pkg::FLAG_PRESENT]) begin
						res_phys_d = {tbl_rd_q[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::FRAME_W],
							cur_q.offset};
					end else begin
						res_status_d = tlpt_pkg::STS_NOT_MAPPED;
						res_phys_d   = '1;
					end
				end
			end
			default: begin
				state_d = tlpt_pkg::BK_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		if (q_pop) begin
			dir_rd_q <= dir_mem[q_item.dir_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[tbl_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_phys_q   <= res_phys_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlpt_pkg::BK_CLEAR;
			used_q      <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (used_inc) begin
				used_q <= used_q + USED_W'(1);
			end
			if (clr_run) begin
				clr_q <= clr_q + TADDR_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.status      = res_status_q;
	assign rsp.phys_result = res_phys_q;

endmodule

### rtl/two_level_page_table_manager.sv
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// 32-bit two-level page table: map, unmap and translate over a table pool
// ----------------------------------------------------------------------------
// After reset the block sweeps its stores, one directory and one table entry
// per cycle, and carries out no command until that is done; the queue still
// takes up to two commands meanwhile. Commands enter a two-entry queue, and
// one more is held by the back end, so req.ready stays high for up to three
// more commands while a result waits on rsp. The back end handles one
// command at a time: map and unmap go through queue pop with directory read,
// then decision and write-back; translate of a present directory entry adds
// a table read after the directory read. The two dependent memory reads set
// this sequence. Table slots are handed out in order and never returned; a
// map past the last slot answers status 1.
module two_level_page_table_manager #(
	parameter int TABLE_POOL = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tlpt_req_if.sink   req,
	tlpt_rsp_if.source rsp
);

	logic            q_valid;
	logic            q_pop;
	tlpt_pkg::item_t q_item;

	tlpt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	tlpt_back #(
		.TABLE_POOL (TABLE_POOL)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

### verif/two_level_page_table_manager_tb.sv
// ----------------------------------------------------------------------------
// two_level_page_table_manager_tb
// self-checking bench for the two-level page table manager
// ----------------------------------------------------------------------------
// Keeps a shadow directory, table pool and slot counter that are updated on
// each accepted command. The expected status and address are queued and
// compared with each response in order. Directed checks cover empty tables,
// address and flag extremes, remap, unmap and pool exhaustion. They are
// followed by a long back-pressure burst and random traffic that mostly hits
// mapped directory entries. Both channels idle at random.
module two_level_page_table_manager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_POOL     = 16;
	localparam int SLOT_LSB       = 3;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int BURST_ITEMS    = 24;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 16;
	localparam int MAX_REPORTS    = 10;
	// the reset sweep alone is quiet on both channels, so the limit outlasts it
	localparam int WATCHDOG_LIMIT = 70000;

	localparam logic [tlpt_pkg::CMD_W-1:0] CMD_RSVD = 2'd3;

	typedef struct {
		logic [tlpt_pkg::STATUS_W-1:0] status;
		logic [tlpt_pkg::ADDR_W-1:0]   phys;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;

	tlpt_req_if req_ch ();
	tlpt_rsp_if rsp_ch ();

	two_level_page_table_manager #(
		.TABLE_POOL(TABLE_POOL)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the page tables
	logic [6:0]                  dir_shadow [tlpt_pkg::DIR_ENTRIES];
	logic [tlpt_pkg::ADDR_W-1:0] tbl_shadow [TABLE_POOL*tlpt_pkg::TABLE_ENTRIES];
	int unsigned                 slots_used;
	logic [tlpt_pkg::IDX_W-1:0]  mapped_dirs [$];

	answer_t     answer_q [$];
	int unsigned mismatch_cnt;

	logic src_idle_en;
	logic snk_idle_en;
	logic snk_hold_req;

	function automatic int unsigned tbl_index(logic [6:0] de,
			logic [tlpt_pkg::IDX_W-1:0] ti);
		return de[6:SLOT_LSB] * tlpt_pkg::TABLE_ENTRIES + ti;
	endfunction

	// apply one accepted command to the shadow tables and queue its answer
	function automatic void walk_and_update(logic [tlpt_pkg::CMD_W-1:0] c,
			logic [tlpt_pkg::ADDR_W-1:0] va, logic [tlpt_pkg::ADDR_W-1:0] pa,
			logic [tlpt_pkg::FLAGS_W-1:0] fl);
		logic [tlpt_pkg::IDX_W-1:0]  di;
		logic [tlpt_pkg::IDX_W-1:0]  ti;
		logic [6:0]                  de;
		logic [tlpt_pkg::ADDR_W-1:0] te;
		logic [3:0]                  slot;
		answer_t                     a;
		di = va[31:22];
		ti = va[21:12];
		de = dir_shadow[di];
		a.status = tlpt_pkg::STS_OK;
		a.phys = '0;
		case (c)
			tlpt_pkg::CMD_MAP: begin
				if (!de[tlpt_pkg::FLAG_PRESENT]) begin
					if (slots_used >= TABLE_POOL) begin
						a.status = tlpt_pkg::STS_NO_TABLE;
					end else begin
						slot = slots_used[3:0];
						slots_used++;
						for (int i = 0; i < tlpt_pkg::TABLE_ENTRIES; i++)
							tbl_shadow[slot * tlpt_pkg::TABLE_ENTRIES + i] = '0;
						de = {slot, fl[tlpt_pkg::FLAG_USER], 1'b1, 1'b1};
						dir_shadow[di] = de;
						mapped_dirs.push_back(di);
					end
				end
				// present bit forced on whatever the flags say
				if (a.status == tlpt_pkg::STS_OK)
					tbl_shadow[tbl_index(de, ti)] = {pa[31:12], fl} | 32'h1;
			end
			tlpt_pkg::CMD_UNMAP: begin
				if (de[tlpt_pkg::FLAG_PRESENT])
					tbl_shadow[tbl_index(de, ti)] = '0;
			end
			tlpt_pkg::CMD_XLATE: begin
				te = de[tlpt_pkg::FLAG_PRESENT] ? tbl_shadow[tbl_index(de, ti)] : '0;
				if (te[tlpt_pkg::FLAG_PRESENT]) begin
					a.phys = {te[31:12], va[11:0]};
				end else begin
					a.status = tlpt_pkg::STS_NOT_MAPPED;
					a.phys = '1;
				end
			end
			default: ;
		endcase
		answer_q.push_back(a);
	endfunction

	function automatic void check_answer(logic [tlpt_pkg::STATUS_W-1:0] st,
			logic [tlpt_pkg::ADDR_W-1:0] pr);
		answer_t a;
		if (answer_q.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("unexpected response: status %0d phys_result %h", st, pr);
			return;
		end
		a = answer_q.pop_front();
		if (st !== a.status || pr !== a.phys) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("mismatch: status exp %0d got %0d, phys_result exp %h got %h",
					a.status, st, a.phys, pr);
		end
	endfunction

	function automatic logic [tlpt_pkg::IDX_W-1:0] pick_absent_dir();
		logic [tlpt_pkg::IDX_W-1:0] di;
		do
			di = 10'($urandom_range(1, tlpt_pkg::DIR_ENTRIES - 2));
		while (dir_shadow[di][tlpt_pkg::FLAG_PRESENT]);
		return di;
	endfunction

	// valid stays high back to back unless a gap is drawn
	task automatic send_cmd(input logic [tlpt_pkg::CMD_W-1:0] c,
			input logic [tlpt_pkg::ADDR_W-1:0] va, input logic [tlpt_pkg::ADDR_W-1:0] pa,
			input logic [tlpt_pkg::FLAGS_W-1:0] fl);
		int unsigned gap;
		gap = src_idle_en ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.virt_addr  <= va;
		req_ch.phys_addr  <= pa;
		req_ch.page_flags <= fl;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		walk_and_update(c, va, pa, fl);
	endtask

	task automatic send_random_item();
		logic [tlpt_pkg::CMD_W-1:0] c;
		logic [tlpt_pkg::IDX_W-1:0] di;
		logic [tlpt_pkg::IDX_W-1:0] ti;
		int unsigned                pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c = tlpt_pkg::CMD_MAP;
		else if (pick < 55)
			c = tlpt_pkg::CMD_UNMAP;
		else if (pick < 95)
			c = tlpt_pkg::CMD_XLATE;
		else
			c = CMD_RSVD;
		// mostly hit directories that own a table so the walk goes deep
		if (mapped_dirs.size() != 0 && $urandom_range(0, 99) < 85)
			di = mapped_dirs[$urandom_range(0, mapped_dirs.size() - 1)];
		else
			di = 10'($urandom_range(0, tlpt_pkg::DIR_ENTRIES - 1));
		pick = $urandom_range(0, 99);
		if (pick < 35)
			ti = 10'($urandom_range(0, 3));
		else if (pick < 70)
			ti = 10'($urandom_range(tlpt_pkg::TABLE_ENTRIES - 4,
				tlpt_pkg::TABLE_ENTRIES - 1));
		else
			ti = 10'($urandom_range(0, tlpt_pkg::TABLE_ENTRIES - 1));
		send_cmd(c, {di, ti, 12'($urandom)}, $urandom, 12'($urandom));
	endtask

	task automatic test_empty_tables();
		send_cmd(tlpt_pkg::CMD_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h0);
		send_cmd(tlpt_pkg::CMD_UNMAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
		send_cmd(CMD_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
	endtask

	task automatic test_map_extremes();
		send_cmd(tlpt_pkg::CMD_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'h000);
		send_cmd(tlpt_pkg::CMD_XLATE, 32'h0000_0FFF, 32'h0, 12'h0);
		send_cmd(tlpt_pkg::CMD_MAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'hFFF);
		send_cmd(tlpt_pkg::CMD_XLATE, 32'hFFFF_F000, 32'h0, 12'h0);
		send_cmd(tlpt_pkg::CMD_XLATE, 32'hFFFF_EFFF, 32'h0, 12'h0);
	endtask

	task automatic test_remap_unmap();
		// directory entry already present: only the table entry changes
		send_cmd(tlpt_pkg::CMD_MAP, 32'h0000_0123, 32'h1234_5FFF, 12'h004);
		send_cmd(tlpt_pkg::CMD_XLATE, 32'h0000_0ABC, 32'h0, 12'h0);
		send_cmd(tlpt_pkg::CMD_UNMAP, 32'h0000_0000, 32'h0, 12'h0);
		send_cmd(tlpt_pkg::CMD_XLATE, 32'h0000_0ABC, 32'h0, 12'h0);
	endtask

	task automatic test_pool_exhaust();
		logic [tlpt_pkg::IDX_W-1:0] di;
		while (slots_used < TABLE_POOL) begin
			di = pick_absent_dir();
			send_cmd(tlpt_pkg::CMD_MAP, {di, 10'($urandom), 12'($urandom)}, $urandom,
				12'($urandom));
		end
		di = pick_absent_dir();
		send_cmd(tlpt_pkg::CMD_MAP, {di, 10'h155, 12'hAAA}, 32'hDEAD_B000, 12'h004);
		send_cmd(tlpt_pkg::CMD_XLATE, {di, 10'h155, 12'hAAA}, 32'h0, 12'h0);
	endtask

	task automatic test_backpressure();
		src_idle_en = 1'b0;
		snk_hold_req = 1'b1;
		repeat (BURST_ITEMS) send_random_item();
		src_idle_en = 1'b1;
	endtask

	task automatic test_random_traffic();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// alternate stretches with and without idle cycles
			if (n % 64 == 0) begin
				src_idle_en = $urandom_range(0, 3) != 0;
				snk_idle_en = $urandom_range(0, 3) != 0;
			end
			send_random_item();
		end
	endtask

	// response side: random ready gaps, one long hold on request
	initial begin : rsp_drain
		int unsigned idle_left;
		int unsigned hold_left;
		idle_left = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				check_answer(rsp_ch.status, rsp_ch.phys_result);
				idle_left = snk_idle_en ? $urandom_range(0, 10) : 0;
			end
			if (snk_hold_req) begin
				snk_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (idle_left != 0) begin
				rsp_ch.ready <= 1'b0;
				idle_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : main
		foreach (dir_shadow[i])
			dir_shadow[i] = '0;
		foreach (tbl_shadow[i])
			tbl_shadow[i] = '0;
		slots_used = 0;
		mismatch_cnt = 0;
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		snk_hold_req = 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.cmd        <= tlpt_pkg::CMD_MAP;
		req_ch.virt_addr  <= '0;
		req_ch.phys_addr  <= '0;
		req_ch.page_flags <= '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_tables();
		test_map_extremes();
		test_remap_unmap();
		test_pool_exhaust();
		test_backpressure();
		test_random_traffic();

		req_ch.valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && answer_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
rtl/tlpt_pkg.sv
rtl/tlpt_req_if.sv
rtl/tlpt_rsp_if.sv
rtl/tlpt_front.sv
rtl/tlpt_back.sv
rtl/two_level_page_table_manager.sv
verif/two_level_page_table_manager_tb.sv
